@@ hdl/r2fft_pkg.sv @@
// Shared types, constants and twiddle table functions for the radix-2 FFT engine.
package r2fft_pkg;

    localparam int LOG2_MAX_POINTS = 10;
    localparam int MAX_POINTS      = 1 << LOG2_MAX_POINTS;
    localparam int HALF_POINTS     = MAX_POINTS >> 1;
    localparam int SAMPLE_BITS     = 16;
    localparam int WORK_BITS       = 32;
    localparam int TWIDDLE_BITS    = 16;
    localparam int IDX_W           = LOG2_MAX_POINTS;
    localparam int TW_ADDR_W       = LOG2_MAX_POINTS - 1;
    localparam int STAGE_W         = 4;
    localparam int PROD_W          = TWIDDLE_BITS + 1 + WORK_BITS;
    localparam int TW_SHIFT        = TWIDDLE_BITS - 1;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // operation codes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;   // unassigned, always rejected

    // status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // configuration register indexes
    localparam logic CFG_DIRECTION = 1'b0;
    localparam logic CFG_LOG2_SIZE = 1'b1;

    typedef struct packed {
        logic [1:0]                     operation;
        logic [IDX_W-1:0]               index;
        logic signed [SAMPLE_BITS-1:0]  sample_re;
        logic signed [SAMPLE_BITS-1:0]  sample_im;
    } in_item_t;

    typedef struct packed {
        logic signed [WORK_BITS-1:0] bin_re;
        logic signed [WORK_BITS-1:0] bin_im;
        logic [IDX_W-1:0]            bin_index;
        logic                        status;
    } out_item_t;

    typedef struct packed {
        logic b_ld;     // capture lower-leg operand
        logic mul_en;   // form products, capture upper-leg operand
        logic add_en;   // scale products, form sum and difference
    } bfly_ctl_t;

    // cos or sin in Q30 of r * 2*pi / 32768, r in 0..4096 (series evaluation)
    function automatic logic signed [63:0] octant_q30(input int unsigned r, input bit want_sin);
        logic [63:0]        x;
        logic [63:0]        t;
        logic signed [63:0] acc;
        int                 k;
        x = (64'(r) * TWO_PI_Q30) >> 15;
        if (want_sin)
        begin
            t   = x;
            acc = $signed(x);
        end
        else
        begin
            t   = 64'd1 << 30;
            acc = $signed(t);
        end
        for (k = 1; k <= 9; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            if (want_sin)
                t = t / 64'((2 * k) * (2 * k + 1));
            else
                t = t / 64'((2 * k - 1) * (2 * k));
            if ((k & 1) == 1)
                acc = acc - $signed(t);
            else
                acc = acc + $signed(t);
        end
        return acc;
    endfunction

    // Q30 to Q1.(TWIDDLE_BITS-1), round to nearest, +1.0 saturates
    function automatic logic [TWIDDLE_BITS-1:0] to_twiddle(input logic signed [63:0] q30,
                                                           input bit neg);
        logic signed [63:0] v;
        logic signed [63:0] top;
        v   = (q30 < 0) ? 64'sd0 : q30;
        top = (64'sd1 <<< (TWIDDLE_BITS - 1)) - 64'sd1;
        v   = (v + (64'sd1 <<< (30 - TWIDDLE_BITS))) >>> (31 - TWIDDLE_BITS);
        if (neg)
            v = -v;
        else if (v > top)
            v = top;
        return v[TWIDDLE_BITS-1:0];
    endfunction

    // {cos, sin} for twiddle slot m
    function automatic logic [2*TWIDDLE_BITS-1:0] tw_word(input int unsigned m);
        int unsigned        u;
        int unsigned        q;
        int unsigned        r;
        logic signed [63:0] c0;
        logic signed [63:0] s0;
        logic [TWIDDLE_BITS-1:0] cw;
        logic [TWIDDLE_BITS-1:0] sw;
        u = (m << (15 - LOG2_MAX_POINTS)) & 32767;
        q = u >> 13;
        r = u & 8191;
        if (r <= 4096)
        begin
            c0 = octant_q30(r, 1'b0);
            s0 = octant_q30(r, 1'b1);
        end
        else
        begin
            s0 = octant_q30(8192 - r, 1'b0);
            c0 = octant_q30(8192 - r, 1'b1);
        end
        case (q)
            0:
            begin
                cw = to_twiddle(c0, 1'b0);
                sw = to_twiddle(s0, 1'b0);
            end
            1:
            begin
                cw = to_twiddle(s0, 1'b1);
                sw = to_twiddle(c0, 1'b0);
            end
            2:
            begin
                cw = to_twiddle(c0, 1'b1);
                sw = to_twiddle(s0, 1'b1);
            end
            default:
            begin
                cw = to_twiddle(s0, 1'b0);
                sw = to_twiddle(c0, 1'b1);
            end
        endcase
        return {cw, sw};
    endfunction

endpackage

@@ hdl/r2fft_twrom.sv @@
// Twiddle ROM: registered {cos, sin} lookup built at elaboration.
module r2fft_twrom
    import r2fft_pkg::*;
(
    input  logic                        clk,
    input  logic [TW_ADDR_W-1:0]        addr,
    output logic [2*TWIDDLE_BITS-1:0]   q
);

    logic [2*TWIDDLE_BITS-1:0] rom [HALF_POINTS];
    logic [2*TWIDDLE_BITS-1:0] q_reg;

    for (genvar g = 0; g < HALF_POINTS; g++)
    begin : g_rom
        assign rom[g] = tw_word(g);
    end

    always_ff @(posedge clk)
    begin
        q_reg <= rom[addr];
    end

    assign q = q_reg;

endmodule

@@ hdl/r2fft_bfly.sv @@
// Butterfly datapath: complex twiddle multiply, truncating shift, sum and difference.
module r2fft_bfly
    import r2fft_pkg::*;
(
    input  logic                        clk,
    input  bfly_ctl_t                   ctl,
    input  logic                        direction,
    input  logic [2*WORK_BITS-1:0]      din,
    input  logic [2*TWIDDLE_BITS-1:0]   tw,
    output logic [2*WORK_BITS-1:0]      sum,
    output logic [2*WORK_BITS-1:0]      diff
);

    logic [2*WORK_BITS-1:0]          b_reg;
    logic [2*WORK_BITS-1:0]          a_reg;
    logic signed [PROD_W-1:0]        rr_reg, ii_reg, ri_reg, ir_reg;
    logic [2*WORK_BITS-1:0]          sum_reg, diff_reg;

    logic signed [TWIDDLE_BITS:0]    w_re, w_im, sin_x;
    logic signed [WORK_BITS-1:0]     b_re, b_im, a_re, a_im;
    logic signed [PROD_W:0]          t_re_full, t_im_full;
    logic [WORK_BITS-1:0]            t_re, t_im;

    always_comb
    begin
        w_re  = {tw[2*TWIDDLE_BITS-1], tw[2*TWIDDLE_BITS-1:TWIDDLE_BITS]};
        sin_x = {tw[TWIDDLE_BITS-1], tw[TWIDDLE_BITS-1:0]};
        w_im  = direction ? sin_x : -sin_x;
        b_re  = b_reg[2*WORK_BITS-1:WORK_BITS];
        b_im  = b_reg[WORK_BITS-1:0];
        a_re  = a_reg[2*WORK_BITS-1:WORK_BITS];
        a_im  = a_reg[WORK_BITS-1:0];
        t_re_full = (PROD_W+1)'(rr_reg) - (PROD_W+1)'(ii_reg);
        t_im_full = (PROD_W+1)'(ri_reg) + (PROD_W+1)'(ir_reg);
        // only the low work bits survive the wrap
        t_re = t_re_full[TW_SHIFT+WORK_BITS-1:TW_SHIFT];
        t_im = t_im_full[TW_SHIFT+WORK_BITS-1:TW_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.b_ld)
            b_reg <= din;
        if (ctl.mul_en)
        begin
            a_reg  <= din;
            rr_reg <= PROD_W'(w_re * b_re);
            ii_reg <= PROD_W'(w_im * b_im);
            ri_reg <= PROD_W'(w_re * b_im);
            ir_reg <= PROD_W'(w_im * b_re);
        end
        if (ctl.add_en)
        begin
            sum_reg  <= {WORK_BITS'(a_re + t_re), WORK_BITS'(a_im + t_im)};
            diff_reg <= {WORK_BITS'(a_re - t_re), WORK_BITS'(a_im - t_im)};
        end
    end

    assign sum  = sum_reg;
    assign diff = diff_reg;

endmodule

@@ hdl/radix2_fft_engine_unit.sv @@
// Top level of the in-place radix-2 decimation-in-time FFT engine.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  in       | input     | in_valid / in_stall  | in_data  (in_item_t)
//  out      | output    | out_valid / out_stall| out_data (out_item_t)
//  cfg      | input     | cfg_write            | cfg_index, cfg_data
//
// Loads and reads sustain one beat per cycle while the output is not stalled;
// a read's bin passes from the registered work memory output to the output
// register as its beat leaves the result holding stage. A run takes each
// butterfly through RDB, RDA, MUL, ADD, WRA, WRB per stage; an inverse then
// scales each point by 1/N in SRD, SWR. The result beat follows the last
// write. Reset clears control only; the work memory is garbage until loaded.
// in_stall is high during a run or while the result holding stage is blocked.
module radix2_fft_engine_unit
    import r2fft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RDB  = 4'd1;
    localparam logic [3:0] ST_RDA  = 4'd2;
    localparam logic [3:0] ST_MUL  = 4'd3;
    localparam logic [3:0] ST_ADD  = 4'd4;
    localparam logic [3:0] ST_WRA  = 4'd5;
    localparam logic [3:0] ST_WRB  = 4'd6;
    localparam logic [3:0] ST_SRD  = 4'd7;
    localparam logic [3:0] ST_SWR  = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;

    // work memory: {re, im}
    logic [2*WORK_BITS-1:0] mem [MAX_POINTS];
    logic [2*WORK_BITS-1:0] mem_q;
    logic                   mem_rd;
    logic [IDX_W-1:0]       mem_raddr;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [2*WORK_BITS-1:0] mem_wdata;

    logic [3:0]             state_reg, state_next;
    logic                   direction_reg;
    logic [3:0]             log2_size_reg;
    logic                   done_reg, done_next;
    logic [STAGE_W-1:0]     stage_reg, stage_next;
    logic [TW_ADDR_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]       p_reg, p_next;
    logic [IDX_W-1:0]       run_idx_reg, run_idx_next;
    logic                   pend_valid_reg, pend_valid_next;
    out_item_t              pend_reg, pend_next;
    logic                   pend_rd_reg, pend_rd_next;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    logic                   pend_move, in_take, in_range;
    logic [STAGE_W-1:0]     n_eff;
    logic [IDX_W-1:0]       size_mask, rev_idx, load_pos;
    logic [TW_ADDR_W-1:0]   half_mask, k_last, low_k;
    logic [IDX_W-1:0]       a_idx, b_idx;
    logic [TW_ADDR_W-1:0]   tw_addr;
    logic [2*TWIDDLE_BITS-1:0] tw_q;
    logic [2*WORK_BITS-1:0] bf_sum, bf_diff;
    logic signed [WORK_BITS-1:0] sc_re, sc_im;
    bfly_ctl_t              bctl;

    r2fft_twrom u_twrom (
        .clk  (clk),
        .addr (tw_addr),
        .q    (tw_q)
    );

    r2fft_bfly u_bfly (
        .clk       (clk),
        .ctl       (bctl),
        .direction (direction_reg),
        .din       (mem_q),
        .tw        (tw_q),
        .sum       (bf_sum),
        .diff      (bf_diff)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_rd)
            mem_q <= mem[mem_raddr];
    end

    // size and address arithmetic
    always_comb
    begin
        n_eff     = (log2_size_reg > STAGE_W'(LOG2_MAX_POINTS)) ?
                    STAGE_W'(LOG2_MAX_POINTS) : log2_size_reg;
        size_mask = ~({IDX_W{1'b1}} << n_eff);
        in_range  = (in_data.index & ~size_mask) == '0;
        for (int i = 0; i < IDX_W; i++)
            rev_idx[i] = in_data.index[IDX_W-1-i];
        load_pos  = rev_idx >> (STAGE_W'(LOG2_MAX_POINTS) - n_eff);
        k_last    = TW_ADDR_W'(size_mask >> 1);
        half_mask = ~({TW_ADDR_W{1'b1}} << (stage_reg - STAGE_W'(1)));
        low_k     = k_reg & half_mask;
        // insert a zero at bit stage-1 of the butterfly count
        a_idx     = ((IDX_W'(k_reg) & ~IDX_W'(half_mask)) << 1) | IDX_W'(low_k);
        b_idx     = a_idx | (IDX_W'(1) << (stage_reg - STAGE_W'(1)));
        tw_addr   = TW_ADDR_W'(low_k << (STAGE_W'(LOG2_MAX_POINTS) - stage_reg));
        sc_re     = $signed(mem_q[2*WORK_BITS-1:WORK_BITS]) >>> n_eff;
        sc_im     = $signed(mem_q[WORK_BITS-1:0]) >>> n_eff;
    end

    assign pend_move = pend_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = (state_reg != ST_IDLE) || (pend_valid_reg && !pend_move);
    assign in_take   = in_valid && !in_stall;

    always_comb
    begin
        state_next      = state_reg;
        done_next       = done_reg;
        stage_next      = stage_reg;
        k_next          = k_reg;
        p_next          = p_reg;
        run_idx_next    = run_idx_reg;
        pend_valid_next = pend_move ? 1'b0 : pend_valid_reg;
        pend_next       = pend_reg;
        pend_rd_next    = pend_rd_reg;
        mem_rd          = 1'b0;
        mem_raddr       = in_data.index;
        mem_we          = 1'b0;
        mem_waddr       = load_pos;
        mem_wdata       = {WORK_BITS'(in_data.sample_re), WORK_BITS'(in_data.sample_im)};
        bctl            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    pend_next.bin_re    = '0;
                    pend_next.bin_im    = '0;
                    pend_next.bin_index = in_data.index;
                    pend_next.status    = STATUS_REJECT;
                    pend_rd_next        = 1'b0;
                    pend_valid_next     = 1'b1;
                    case (in_data.operation)
                        OP_LOAD:
                        begin
                            if (in_range)
                            begin
                                mem_we           = 1'b1;
                                done_next        = 1'b0;
                                pend_next.status = STATUS_OK;
                            end
                        end
                        OP_RUN:
                        begin
                            // result beat is issued when the run ends
                            pend_valid_next = 1'b0;
                            run_idx_next    = in_data.index;
                            stage_next      = STAGE_W'(1);
                            k_next          = '0;
                            p_next          = '0;
                            if (n_eff != '0)
                                state_next = ST_RDB;
                            else if (direction_reg)
                                state_next = ST_SRD;
                            else
                                state_next = ST_FIN;
                        end
                        OP_READ:
                        begin
                            mem_rd = 1'b1;
                            if (done_reg && in_range)
                            begin
                                pend_rd_next     = 1'b1;
                                pend_next.status = STATUS_OK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RDB:
            begin
                mem_rd     = 1'b1;
                mem_raddr  = b_idx;
                state_next = ST_RDA;
            end
            ST_RDA:
            begin
                mem_rd     = 1'b1;
                mem_raddr  = a_idx;
                bctl.b_ld  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                bctl.mul_en = 1'b1;
                state_next  = ST_ADD;
            end
            ST_ADD:
            begin
                bctl.add_en = 1'b1;
                state_next  = ST_WRA;
            end
            ST_WRA:
            begin
                mem_we     = 1'b1;
                mem_waddr  = a_idx;
                mem_wdata  = bf_sum;
                state_next = ST_WRB;
            end
            ST_WRB:
            begin
                mem_we    = 1'b1;
                mem_waddr = b_idx;
                mem_wdata = bf_diff;
                if (k_reg == k_last)
                begin
                    k_next = '0;
                    if (stage_reg == n_eff)
                        state_next = direction_reg ? ST_SRD : ST_FIN;
                    else
                    begin
                        stage_next = stage_reg + STAGE_W'(1);
                        state_next = ST_RDB;
                    end
                end
                else
                begin
                    k_next     = k_reg + TW_ADDR_W'(1);
                    state_next = ST_RDB;
                end
            end
            ST_SRD:
            begin
                mem_rd     = 1'b1;
                mem_raddr  = p_reg;
                state_next = ST_SWR;
            end
            ST_SWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = p_reg;
                mem_wdata = {sc_re, sc_im};
                if (p_reg == size_mask)
                    state_next = ST_FIN;
                else
                begin
                    p_next     = p_reg + IDX_W'(1);
                    state_next = ST_SRD;
                end
            end
            ST_FIN:
            begin
                if (!pend_valid_reg || pend_move)
                begin
                    pend_valid_next     = 1'b1;
                    pend_next.bin_re    = '0;
                    pend_next.bin_im    = '0;
                    pend_next.bin_index = run_idx_reg;
                    pend_next.status    = STATUS_OK;
                    pend_rd_next        = 1'b0;
                    done_next           = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            direction_reg  <= 1'b0;
            log2_size_reg  <= 4'd10;
            done_reg       <= 1'b0;
            stage_reg      <= '0;
            k_reg          <= '0;
            p_reg          <= '0;
            pend_valid_reg <= 1'b0;
            pend_rd_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            stage_reg      <= stage_next;
            k_reg          <= k_next;
            p_reg          <= p_next;
            pend_valid_reg <= pend_valid_next;
            pend_rd_reg    <= pend_rd_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DIRECTION: direction_reg <= cfg_data[0];
                    CFG_LOG2_SIZE: log2_size_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (pend_move)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_reg    <= pend_next;
        run_idx_reg <= run_idx_next;
        if (pend_move)
        begin
            out_reg <= pend_reg;
            if (pend_rd_reg)
            begin
                out_reg.bin_re <= mem_q[2*WORK_BITS-1:WORK_BITS];
                out_reg.bin_im <= mem_q[WORK_BITS-1:0];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
